>>> src/alt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Associated Legendre table: shared package
// Word widths and the control bundle that the top level hands to the
// serial multiplier.
// ----------------------------------------------------------------------------
package alt_pkg;

   localparam int VAL_W   = 64;
   localparam int ARG_W   = 32;
   localparam int FIELD_W = 4;
   localparam int COEF_W  = 5;
   localparam int ROOT_W  = 31;
   localparam int A_W     = 37;
   localparam int MAG_W   = 36;
   localparam int P_W     = MAG_W + VAL_W + 1;

   typedef struct packed {
      logic start;
      logic frac_shift;
   } mul_ctl_type;

endpackage

>>> src/assoc_legendre_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Associated Legendre table
// Computes every P(n,m) of one argument into a value memory and streams it.
//
// The request channel (req_valid, req_stall, req_argument) carries one
// signed Q2.30 argument per transfer. For each argument the block returns
// (D+1)(D+2)/2 transfers on the response channel, row by row, n ascending
// and m ascending, with rsp_last set on the final one; D is csr_wr_data as
// last written, clamped to 1..MAX_DEGREE (8 after reset).
// The block first takes a square root, then fills the value memory one entry
// at a time on one serial multiplier and one serial divider; only an entry
// that uses the full three-term recurrence takes a second product and a
// division. Streaming reads, loads and offers the values one at a time;
// req_stall stays high from acceptance until the last value has been
// transferred.
// A stalled response holds its value and the block simply waits.
// Reset returns the controller to idle and the degree register to 8; the
// value memory needs no clearing, every entry is written before it is read.
// ----------------------------------------------------------------------------
module assoc_legendre_table #(
   parameter int MAX_DEGREE = 8,
   parameter int FRAC_BITS  = 30
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [alt_pkg::ARG_W-1:0]   req_argument,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [alt_pkg::FIELD_W-1:0]        rsp_degree,
   output logic [alt_pkg::FIELD_W-1:0]        rsp_order,
   output logic signed [alt_pkg::VAL_W-1:0]   rsp_value,
   output logic                               rsp_last,
   input  logic                               csr_wr_en,
   input  logic [alt_pkg::FIELD_W-1:0]        csr_wr_data
);
   import alt_pkg::*;

   localparam int DEPTH = (MAX_DEGREE + 1) * (MAX_DEGREE + 2) / 2;
   localparam int IW    = $clog2(DEPTH);
   localparam logic [FIELD_W-1:0] DMAX = FIELD_W'(MAX_DEGREE);
   localparam logic signed [VAL_W-1:0] ONE = VAL_W'(1) << FRAC_BITS;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ROOT, ST_ENTRY, ST_RD1, ST_MUL1, ST_MUL2, ST_DIV, ST_NEXT,
      ST_EMIT_RD, ST_EMIT_LD, ST_EMIT_WAIT
   } state_type;

   function automatic logic [IW-1:0] tidx(input logic [FIELD_W-1:0] n,
                                          input logic [FIELD_W-1:0] m);
      logic [7:0] t;
      t = ((8'(n) * 8'(n + 4'd1)) >> 1) + 8'(m);
      return t[IW-1:0];
   endfunction

   logic signed [VAL_W-1:0] mem [DEPTH];

   state_type               state_ff;
   logic [FIELD_W-1:0]      csr_ff;
   logic [FIELD_W-1:0]      d_ff;
   logic signed [ARG_W-1:0] x_ff;
   logic [ROOT_W-1:0]       root_ff;
   logic [VAL_W-1:0]        v_ff;
   logic [VAL_W-1:0]        res_ff;
   logic [VAL_W-1:0]        bit_ff;
   logic [4:0]              sq_cnt_ff;
   logic [FIELD_W-1:0]      n_ff;
   logic [FIELD_W-1:0]      m_ff;
   logic signed [A_W-1:0]   c1_ff;
   logic signed [VAL_W-1:0] t1_ff;
   logic signed [VAL_W-1:0] rd_data_ff;
   logic                    rsp_valid_ff;
   logic [FIELD_W-1:0]      rsp_degree_ff;
   logic [FIELD_W-1:0]      rsp_order_ff;
   logic signed [VAL_W-1:0] rsp_value_ff;
   logic                    rsp_last_ff;

   logic [FIELD_W-1:0]      deff;
   logic signed [VAL_W-1:0] xx;
   logic signed [VAL_W-1:0] r_raw;
   logic [VAL_W-1:0]        r_clamp;
   logic [VAL_W-1:0]        sq_sum;
   logic                    sq_ge;
   logic [VAL_W-1:0]        res_in;
   logic [VAL_W-1:0]        v_in;
   logic                    diag;
   logic                    has2;
   logic [COEF_W-1:0]       c_n;
   logic [COEF_W-1:0]       c_m;
   logic [COEF_W-1:0]       k_nm;
   logic [FIELD_W-1:0]      dv;
   logic signed [A_W-1:0]   coef_x;
   logic signed [A_W-1:0]   coef_s;
   logic                    rd_en;
   logic [IW-1:0]           rd_addr;
   logic                    wr_en;
   logic [IW-1:0]           wr_addr;
   logic signed [VAL_W-1:0] wr_data;
   mul_ctl_type             mul_ctl;
   logic signed [A_W-1:0]   mul_a;
   logic                    mul_done;
   logic signed [VAL_W-1:0] mul_product;
   logic signed [VAL_W:0]   diff_w;
   logic signed [VAL_W-1:0] diff;
   logic                    div_start;
   logic                    div_done;
   logic signed [VAL_W-1:0] div_q;
   logic                    emit_last;

   always_comb begin
      if (csr_ff == '0) begin
         deff = FIELD_W'(1);
      end else if (csr_ff > DMAX) begin
         deff = DMAX;
      end else begin
         deff = csr_ff;
      end
      xx      = $signed(req_argument) * $signed(req_argument);
      r_raw   = ONE - (xx >>> FRAC_BITS);
      r_clamp = r_raw[VAL_W-1] ? '0 : r_raw;

      sq_sum = res_ff + bit_ff;
      sq_ge  = v_ff >= sq_sum;
      res_in = sq_ge ? ((res_ff >> 1) + bit_ff) : (res_ff >> 1);
      v_in   = sq_ge ? (v_ff - sq_sum) : v_ff;

      diag   = (n_ff == m_ff);
      has2   = {1'b0, n_ff} >= ({1'b0, m_ff} + 5'd2);
      c_n    = 5'({n_ff, 1'b0}) - 5'd1;
      c_m    = 5'({m_ff, 1'b0}) - 5'd1;
      k_nm   = 5'(n_ff) + 5'(m_ff) - 5'd1;
      dv     = n_ff - m_ff;
      coef_x = $signed({32'b0, c_n}) * $signed({{5{x_ff[ARG_W-1]}}, x_ff});
      coef_s = -($signed({32'b0, c_m}) * $signed({6'b0, root_ff}));

      diff_w = {t1_ff[VAL_W-1], t1_ff} - {mul_product[VAL_W-1], mul_product};
      if (diff_w[VAL_W] != diff_w[VAL_W-1]) begin
         diff = diff_w[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
      end else begin
         diff = diff_w[VAL_W-1:0];
      end

      rd_en   = 1'b0;
      rd_addr = diag ? tidx(m_ff - 4'd1, m_ff - 4'd1) : tidx(n_ff - 4'd1, m_ff);
      case (state_ff)
         ST_ENTRY:   rd_en = 1'b1;
         ST_RD1: begin
            rd_en   = has2;
            rd_addr = tidx(n_ff - 4'd2, m_ff);
         end
         ST_EMIT_RD: begin
            rd_en   = 1'b1;
            rd_addr = tidx(n_ff, m_ff);
         end
         default: rd_en = 1'b0;
      endcase

      mul_ctl.start      = (state_ff == ST_RD1) ||
                           (state_ff == ST_MUL1 && mul_done && has2);
      mul_ctl.frac_shift = (state_ff == ST_RD1);
      mul_a = (state_ff == ST_RD1) ? c1_ff : $signed({32'b0, k_nm});
      div_start = (state_ff == ST_MUL2) && mul_done;

      wr_en   = 1'b0;
      wr_addr = tidx(n_ff, m_ff);
      wr_data = mul_product;
      case (state_ff)
         ST_ROOT: begin
            wr_en   = (sq_cnt_ff == 5'd31);
            wr_addr = '0;
            wr_data = ONE;
         end
         ST_MUL1: wr_en = mul_done && !has2;
         ST_DIV: begin
            wr_en   = div_done;
            wr_data = div_q;
         end
         default: wr_en = 1'b0;
      endcase

      emit_last = (n_ff == d_ff) && (m_ff == d_ff);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   alt_mul #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mul_ctl),
      .mul_a   (mul_a),
      .mul_b   (rd_data_ff),
      .done    (mul_done),
      .product (mul_product)
   );

   alt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (diff),
      .divisor  (dv),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         csr_ff       <= FIELD_W'(8);
         root_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            csr_ff <= csr_wr_data;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  x_ff      <= req_argument;
                  d_ff      <= deff;
                  v_ff      <= r_clamp << FRAC_BITS;
                  res_ff    <= '0;
                  bit_ff    <= VAL_W'(1) << 62;
                  sq_cnt_ff <= '0;
                  state_ff  <= ST_ROOT;
               end
            end
            ST_ROOT: begin
               v_ff      <= v_in;
               res_ff    <= res_in;
               bit_ff    <= bit_ff >> 2;
               sq_cnt_ff <= sq_cnt_ff + 5'd1;
               if (sq_cnt_ff == 5'd31) begin
                  root_ff  <= res_in[ROOT_W-1:0];
                  n_ff     <= FIELD_W'(1);
                  m_ff     <= '0;
                  state_ff <= ST_ENTRY;
               end
            end
            ST_ENTRY: begin
               c1_ff    <= diag ? coef_s : coef_x;
               state_ff <= ST_RD1;
            end
            ST_RD1: state_ff <= ST_MUL1;
            ST_MUL1: begin
               if (mul_done) begin
                  t1_ff    <= mul_product;
                  state_ff <= has2 ? ST_MUL2 : ST_NEXT;
               end
            end
            ST_MUL2: begin
               if (mul_done) begin
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  state_ff <= ST_NEXT;
               end
            end
            ST_NEXT: begin
               if (n_ff < d_ff) begin
                  n_ff     <= n_ff + 4'd1;
                  state_ff <= ST_ENTRY;
               end else if (m_ff < d_ff) begin
                  m_ff     <= m_ff + 4'd1;
                  n_ff     <= m_ff + 4'd1;
                  state_ff <= ST_ENTRY;
               end else begin
                  n_ff     <= '0;
                  m_ff     <= '0;
                  state_ff <= ST_EMIT_RD;
               end
            end
            ST_EMIT_RD: state_ff <= ST_EMIT_LD;
            ST_EMIT_LD: begin
               rsp_valid_ff  <= 1'b1;
               rsp_degree_ff <= n_ff;
               rsp_order_ff  <= m_ff;
               rsp_value_ff  <= rd_data_ff;
               rsp_last_ff   <= emit_last;
               state_ff      <= ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  if (emit_last) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     if (m_ff < n_ff) begin
                        m_ff <= m_ff + 4'd1;
                     end else begin
                        n_ff <= n_ff + 4'd1;
                        m_ff <= '0;
                     end
                     state_ff <= ST_EMIT_RD;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_degree = rsp_degree_ff;
   assign rsp_order  = rsp_order_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

>>> src/alt_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial multiplier with shift and saturation
// Forms (a * b) >> sh, sh being zero or the fraction width, one bit of the
// magnitude of a per cycle, then saturates the result to 64 bits.
// ----------------------------------------------------------------------------
module alt_mul #(
   parameter int FRAC_BITS = 30
) (
   input  logic                             clock,
   input  logic                             reset,
   input  alt_pkg::mul_ctl_type             ctl,
   input  logic signed [alt_pkg::A_W-1:0]   mul_a,
   input  logic signed [alt_pkg::VAL_W-1:0] mul_b,
   output logic                             done,
   output logic signed [alt_pkg::VAL_W-1:0] product
);
   import alt_pkg::*;

   typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIN} mstate_type;

   mstate_type             state_ff;
   logic                   done_ff;
   logic                   neg_ff;
   logic                   frac_ff;
   logic [MAG_W-1:0]       amag_ff;
   logic [P_W-2:0]         mcand_ff;
   logic [P_W-2:0]         acc_ff;
   logic signed [VAL_W-1:0] product_ff;

   logic signed [A_W-1:0]   abs_a;
   logic signed [VAL_W-1:0] abs_b;
   logic signed [P_W-1:0]   prod;
   logic signed [P_W-1:0]   shifted;
   logic                    fits;
   logic signed [VAL_W-1:0] sat_in;

   always_comb begin
      abs_a   = mul_a[A_W-1] ? -mul_a : mul_a;
      abs_b   = mul_b[VAL_W-1] ? -mul_b : mul_b;
      prod    = neg_ff ? -$signed({1'b0, acc_ff}) : $signed({1'b0, acc_ff});
      shifted = frac_ff ? (prod >>> FRAC_BITS) : prod;
      fits    = (&shifted[P_W-1:VAL_W-1]) | ~(|shifted[P_W-1:VAL_W-1]);
      if (fits) begin
         sat_in = shifted[VAL_W-1:0];
      end else if (shifted[P_W-1]) begin
         sat_in = {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
         sat_in = {1'b0, {(VAL_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            M_IDLE: begin
               if (ctl.start) begin
                  neg_ff   <= mul_a[A_W-1] ^ mul_b[VAL_W-1];
                  frac_ff  <= ctl.frac_shift;
                  amag_ff  <= abs_a[MAG_W-1:0];
                  mcand_ff <= {{(P_W-1-VAL_W){1'b0}}, abs_b};
                  acc_ff   <= '0;
                  state_ff <= M_RUN;
               end
            end
            M_RUN: begin
               if (amag_ff == '0) begin
                  state_ff <= M_FIN;
               end else begin
                  if (amag_ff[0]) begin
                     acc_ff <= acc_ff + mcand_ff;
                  end
                  mcand_ff <= {mcand_ff[P_W-3:0], 1'b0};
                  amag_ff  <= {1'b0, amag_ff[MAG_W-1:1]};
               end
            end
            M_FIN: begin
               product_ff <= sat_in;
               done_ff    <= 1'b1;
               state_ff   <= M_IDLE;
            end
            default: state_ff <= M_IDLE;
         endcase
      end
   end

   assign done    = done_ff;
   assign product = product_ff;

endmodule

>>> src/alt_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial divider by a small integer
// Restoring division of a signed 64-bit word by a 4-bit divisor, one quotient
// bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module alt_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [alt_pkg::VAL_W-1:0]   dividend,
   input  logic [alt_pkg::FIELD_W-1:0]        divisor,
   output logic                               done,
   output logic signed [alt_pkg::VAL_W-1:0]   quotient
);
   import alt_pkg::*;

   typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_type;

   dstate_type              state_ff;
   logic                    done_ff;
   logic                    neg_ff;
   logic [FIELD_W-1:0]      dv_ff;
   logic [FIELD_W-1:0]      rem_ff;
   logic [VAL_W-1:0]        mag_ff;
   logic [5:0]              cnt_ff;
   logic signed [VAL_W-1:0] quot_ff;

   logic signed [VAL_W-1:0] abs_n;
   logic [FIELD_W:0]        rem_sh;
   logic                    qbit;
   logic [FIELD_W:0]        rem_sub;

   always_comb begin
      abs_n   = dividend[VAL_W-1] ? -dividend : dividend;
      rem_sh  = {rem_ff, mag_ff[VAL_W-1]};
      qbit    = rem_sh >= {1'b0, dv_ff};
      rem_sub = rem_sh - {1'b0, dv_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            D_IDLE: begin
               if (start) begin
                  neg_ff   <= dividend[VAL_W-1];
                  mag_ff   <= abs_n;
                  dv_ff    <= divisor;
                  rem_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= D_RUN;
               end
            end
            D_RUN: begin
               rem_ff <= qbit ? rem_sub[FIELD_W-1:0] : rem_sh[FIELD_W-1:0];
               mag_ff <= {mag_ff[VAL_W-2:0], qbit};
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd63) begin
                  state_ff <= D_FIN;
               end
            end
            D_FIN: begin
               quot_ff  <= neg_ff ? -$signed(mag_ff) : $signed(mag_ff);
               done_ff  <= 1'b1;
               state_ff <= D_IDLE;
            end
            default: state_ff <= D_IDLE;
         endcase
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Associated Legendre table testbench
// Feeds arguments to assoc_legendre_table at several degree settings and
// predicts every P(n,m) in fixed point, then checks each response transfer
// field by field, in order, against the predicted table.
// ----------------------------------------------------------------------------

class legendre_scoreboard;

   typedef struct {
      logic [alt_pkg::FIELD_W-1:0] degree;
      logic [alt_pkg::FIELD_W-1:0] order;
      longint                      value;
      logic                        last;
   } table_entry_type;

   table_entry_type pending_values[$];
   logic [alt_pkg::FIELD_W-1:0] degree_reg = 4'd8;
   logic [alt_pkg::ROOT_W-1:0]  root = '0;
   int failures = 0;

   function automatic longint mul_shift(longint a, longint b, int sh);
      logic signed [127:0] pa, pb, p;
      pa = a;
      pb = b;
      p = (pa * pb) >>> sh;
      if (p > 128'sh7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
      if (p < -128'sh8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
      return p[63:0];
   endfunction

   function automatic longint diff_sat(longint a, longint b);
      logic signed [64:0] d;
      d = 65'(a) - 65'(b);
      if (d > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
      if (d < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
      return d[63:0];
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic longint three_term(longint c, longint x, longint p1, longint k,
                                         longint p2, longint d);
      return diff_sat(mul_shift(c * x, p1, 30), mul_shift(k, p2, 0)) / d;
   endfunction

   function void set_degree(logic [alt_pkg::FIELD_W-1:0] d);
      degree_reg = d;
   endfunction

   function void note_argument(logic signed [alt_pkg::ARG_W-1:0] arg);
      longint tbl[0:8][0:8];
      longint x, one, xx, r;
      int d, total, k;
      table_entry_type e;
      d = degree_reg;
      if (d < 1) d = 1;
      if (d > 8) d = 8;
      one = 64'sd1 << 30;
      x = arg;
      xx = (x * x) >>> 30;
      r = one - xx;
      if (r < 0) r = 0;
      root = 31'(floor_sqrt(longint'(r) << 30));
      tbl[0][0] = one;
      tbl[1][0] = x;
      for (int n = 2; n <= d; n++)
         tbl[n][0] = three_term(2 * n - 1, x, tbl[n - 1][0], n - 1, tbl[n - 2][0], n);
      for (int m = 1; m <= d; m++) begin
         tbl[m][m] = mul_shift(-(2 * m - 1) * longint'(root), tbl[m - 1][m - 1], 30);
         if (m + 1 <= d) tbl[m + 1][m] = mul_shift((2 * m + 1) * x, tbl[m][m], 30);
         for (int n = m + 2; n <= d; n++)
            tbl[n][m] = three_term(2 * n - 1, x, tbl[n - 1][m], n + m - 1,
                                   tbl[n - 2][m], n - m);
      end
      total = (d + 1) * (d + 2) / 2;
      k = 0;
      for (int n = 0; n <= d; n++) begin
         for (int m = 0; m <= n; m++) begin
            k++;
            e.degree = 4'(n);
            e.order = 4'(m);
            e.value = tbl[n][m];
            e.last = (k == total);
            pending_values.push_back(e);
         end
      end
   endfunction

   function void check_value(logic [3:0] deg, logic [3:0] ord, longint val, logic last);
      table_entry_type e;
      if (pending_values.size() == 0) begin
         $display("%0t: unexpected value n=%0d m=%0d value=%0d", $time, deg, ord, val);
         failures++;
         return;
      end
      e = pending_values.pop_front();
      if (deg !== e.degree) begin
         $display("%0t: degree expected %0d actual %0d", $time, e.degree, deg);
         failures++;
      end
      if (ord !== e.order) begin
         $display("%0t: order expected %0d actual %0d", $time, e.order, ord);
         failures++;
      end
      if (val !== e.value) begin
         $display("%0t: value P(%0d,%0d) expected %0d actual %0d",
                  $time, e.degree, e.order, e.value, val);
         failures++;
      end
      if (last !== e.last) begin
         $display("%0t: last expected %0b actual %0b", $time, e.last, last);
         failures++;
      end
   endfunction

endclass

module tb;

   localparam int CYCLE_LIMIT = 6000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [alt_pkg::ARG_W-1:0] req_argument = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [alt_pkg::FIELD_W-1:0] rsp_degree, rsp_order;
   logic signed [alt_pkg::VAL_W-1:0] rsp_value;
   logic rsp_last;
   logic csr_wr_en = 1'b0;
   logic [alt_pkg::FIELD_W-1:0] csr_wr_data = '0;

   legendre_scoreboard legendre_sb = new();
   int idle_percent = 16;
   int cycle_count = 0;

   assoc_legendre_table DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_argument(req_argument),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_degree(rsp_degree),
      .rsp_order(rsp_order), .rsp_value(rsp_value), .rsp_last(rsp_last),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < idle_percent);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         legendre_sb.check_value(rsp_degree, rsp_order, rsp_value, rsp_last);
   end

   task automatic send_argument(logic signed [alt_pkg::ARG_W-1:0] arg);
      @(negedge clock);
      while ($urandom_range(99) < idle_percent) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_argument <= arg;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      legendre_sb.note_argument(arg);
   endtask

   task automatic write_degree(logic [alt_pkg::FIELD_W-1:0] d);
      @(negedge clock);
      req_valid <= 1'b0;
      csr_wr_en <= 1'b1;
      csr_wr_data <= d;
      legendre_sb.set_degree(d);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      while (legendre_sb.pending_values.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   function automatic logic signed [31:0] random_argument();
      if ($urandom_range(9) == 0) return $urandom;
      return $signed(32'($urandom_range(32'h8000_0000))) - 32'sh4000_0000;
   endfunction

   logic [3:0] phase_degrees[8] = '{4'd1, 4'd15, 4'd0, 4'd4, 4'd8, 4'd9, 4'd2, 4'd6};
   logic signed [31:0] directed_args[14] = '{
      32'sh4000_0000, -32'sh4000_0000, 32'sh0, 32'sh7FFF_FFFF, 32'sh8000_0000,
      32'sh1, -32'sh1, 32'sh2000_0000, -32'sh2000_0000, 32'sh3FFF_FFFF,
      32'sh4000_0001, -32'sh4000_0001, 32'sh5555_5555, 32'shAAAA_AAAA};

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed_args[i]) send_argument(directed_args[i]);
      drain();
      foreach (phase_degrees[p]) begin
         write_degree(phase_degrees[p]);
         idle_percent = (p == 4) ? 0 : 16;
         repeat (23) send_argument(random_argument());
         drain();
      end
      if (legendre_sb.failures == 0 && legendre_sb.pending_values.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
src/alt_pkg.sv
src/alt_mul.sv
src/alt_div.sv
src/assoc_legendre_table.sv
verif/tb.sv
